### hdl/ipsv_pkg.sv
// ----------------------------------------------------------------------------
// ipsv_pkg
// Shared types and constants for the inverse Park / SVPWM duty unit.
// ----------------------------------------------------------------------------
package ipsv_pkg;

    localparam int QW        = 34;   // width of the bus-divided vector times
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;

    localparam logic [2:0] SEC_N1 = 3'd1;
    localparam logic [2:0] SEC_N2 = 3'd2;
    localparam logic [2:0] SEC_N3 = 3'd3;
    localparam logic [2:0] SEC_N4 = 3'd4;
    localparam logic [2:0] SEC_N5 = 3'd5;
    localparam logic [2:0] SEC_N6 = 3'd6;

    typedef struct packed {
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
        logic signed [15:0] sine_value;
        logic signed [15:0] cosine_value;
        logic [15:0]        bus_voltage;
    } t_in_item;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [2:0]  sector_code;
        logic        times_scaled;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          wdata;
    } t_cfg_item;

    // Job handed from front to back: numerator magnitudes already >> FRAC_BITS
    typedef struct packed {
        logic [QW-1:0] mag1;
        logic [QW-1:0] mag2;
        logic [15:0]   bus;
        logic [2:0]    sector;
    } t_job;

endpackage

### hdl/ipsv_if.sv
// ----------------------------------------------------------------------------
// ipsv channel interfaces
// Valid/ready channels for input items, result items and config writes.
// ----------------------------------------------------------------------------
interface ipsv_in_if import ipsv_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipsv_out_if import ipsv_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipsv_cfg_if import ipsv_pkg::*;;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/ipsv_front.sv
// ----------------------------------------------------------------------------
// ipsv_front
// Inverse Park, sector detection, selection of the two vector-time
// numerators and their scaling by the period; six stages, stalled as a whole when the queue is full.
// ----------------------------------------------------------------------------
module ipsv_front import ipsv_pkg::*; #(
    parameter int FRAC_BITS = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_period,
    input  logic          i_room,
    ipsv_in_if.sink       i_in,
    output logic          o_push,
    output t_job          o_job
);

    localparam longint K866_V  = (64'sd866 * (64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
    localparam longint K1732_V = (64'sd1732 * (64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
    localparam longint K15_V   = (64'sd3 * (64'sd1 <<< FRAC_BITS) + 64'sd1) / 64'sd2;
    localparam int KW = FRAC_BITS + 3;
    localparam int MW = KW + 17;
    localparam int NW = MW + 2;
    localparam int PW = NW + 17;
    localparam logic signed [KW-1:0] K866  = KW'(K866_V);
    localparam logic signed [KW-1:0] K1732 = KW'(K1732_V);
    localparam logic signed [KW-1:0] K15   = KW'(K15_V);

    // beta reaches +65536 when all inputs are -32768, hence 18 bits
    function automatic logic signed [17:0] f_q15(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = {v[32], v} + (v[32] ? 34'sd32767 : 34'sd0);
        return t[32:15];
    endfunction

    logic [6:1] r_v;
    logic       en;
    assign en = i_room;
    assign i_in.ready = en;

    // stage 1
    logic signed [31:0] r1_dc, r1_qs, r1_qc, r1_ds;
    logic [15:0]        r1_bus;
    // stage 2
    logic signed [17:0] r2_alpha, r2_beta;
    logic [15:0]        r2_bus;
    // stage 3
    logic signed [MW-1:0] r3_a866, r3_bh, r3_a15, r3_b866, r3_b1732;
    logic                 r3_bpos;
    logic [15:0]          r3_bus;
    // stage 4
    logic signed [NW-1:0] r4_x, r4_y, r4_z;
    logic [2:0]           r4_sec;
    logic [15:0]          r4_bus;
    // stage 5
    logic signed [NW-1:0] r5_n1, r5_n2;
    logic [2:0]           r5_sec;
    logic [15:0]          r5_bus;
    // stage 6
    logic signed [PW-1:0] r6_m1, r6_m2;
    logic [2:0]           r6_sec;
    logic [15:0]          r6_bus;

    logic signed [NW-1:0] u2, u3, n1, n2;
    logic signed [16:0]   per_s;

    assign per_s = $signed({1'b0, i_period});
    assign u2 = NW'(r3_a866) - NW'(r3_bh);
    assign u3 = -NW'(r3_a866) - NW'(r3_bh);

    always_comb begin
        n1 = '0;
        n2 = '0;
        case (r4_sec)
            SEC_N3: begin n1 = -r4_z; n2 = r4_x;  end
            SEC_N1: begin n1 = r4_z;  n2 = r4_y;  end
            SEC_N5: begin n1 = r4_x;  n2 = -r4_y; end
            SEC_N4: begin n1 = -r4_x; n2 = r4_z;  end
            SEC_N6: begin n1 = -r4_y; n2 = -r4_z; end
            SEC_N2: begin n1 = r4_y;  n2 = -r4_x; end
            default: begin n1 = '0;   n2 = '0;    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:1], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dc  <= i_in.data.volt_d * i_in.data.cosine_value;
            r1_qs  <= i_in.data.volt_q * i_in.data.sine_value;
            r1_qc  <= i_in.data.volt_q * i_in.data.cosine_value;
            r1_ds  <= i_in.data.volt_d * i_in.data.sine_value;
            r1_bus <= i_in.data.bus_voltage;

            r2_alpha <= f_q15(33'(r1_dc) - 33'(r1_qs));
            r2_beta  <= f_q15(33'(r1_qc) + 33'(r1_ds));
            r2_bus   <= r1_bus;

            r3_a866  <= MW'(K866 * r2_alpha);
            r3_bh    <= MW'(r2_beta) <<< (FRAC_BITS - 1);
            r3_a15   <= MW'(K15 * r2_alpha);
            r3_b866  <= MW'(K866 * r2_beta);
            r3_b1732 <= MW'(K1732 * r2_beta);
            r3_bpos  <= (r2_beta > 18'sd0);
            r3_bus   <= r2_bus;

            r4_x   <= NW'(r3_b1732);
            r4_y   <= NW'(r3_a15) + NW'(r3_b866);
            r4_z   <= NW'(r3_b866) - NW'(r3_a15);
            r4_sec <= {(u3 > 0), (u2 > 0), r3_bpos};
            r4_bus <= r3_bus;

            r5_n1  <= n1;
            r5_n2  <= n2;
            r5_sec <= r4_sec;
            r5_bus <= r4_bus;

            r6_m1  <= PW'(r5_n1 * per_s);
            r6_m2  <= PW'(r5_n2 * per_s);
            r6_sec <= r5_sec;
            r6_bus <= r5_bus;
        end
    end

    // non-positive numerators clamp the vector time to zero
    assign o_push = en && r_v[6];
    assign o_job.mag1 = (!r6_m1[PW-1] && r6_m1 != '0) ?
                        r6_m1[FRAC_BITS+QW-1:FRAC_BITS] : '0;
    assign o_job.mag2 = (!r6_m2[PW-1] && r6_m2 != '0) ?
                        r6_m2[FRAC_BITS+QW-1:FRAC_BITS] : '0;
    assign o_job.bus    = (r6_bus == 16'd0) ? 16'd1 : r6_bus;
    assign o_job.sector = r6_sec;

endmodule

### hdl/ipsv_queue.sv
// ----------------------------------------------------------------------------
// ipsv_queue
// Small job FIFO between front and back.
// ----------------------------------------------------------------------------
module ipsv_queue import ipsv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic o_room
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

endmodule

### hdl/ipsv_back.sv
// ----------------------------------------------------------------------------
// ipsv_back
// Divides the vector times by the bus voltage, scales them down to the
// limit when their sum exceeds it, and forms the seven-segment compare values.
// ----------------------------------------------------------------------------
module ipsv_back import ipsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_period,
    input  logic [15:0] i_limit,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    ipsv_out_if.source  o_out
);

    localparam int RW = QW + 16;
    localparam int SW = QW + 1;
    localparam int DW = RW + 1;

    logic      adv;
    logic      r_out_valid;
    t_out_item r_out;

    assign adv   = !r_out_valid || o_out.ready;
    assign o_pop = adv && i_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // bus divider: one quotient bit per stage, quotient replaces dividend bits
    logic          r_dv  [QW+1];
    logic [QW-1:0] r_w1  [QW+1];
    logic [QW-1:0] r_w2  [QW+1];
    logic [15:0]   r_r1  [QW+1];
    logic [15:0]   r_r2  [QW+1];
    logic [15:0]   r_bus [QW+1];
    logic [2:0]    r_dsec[QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w1[0]   <= i_job.mag1;
            r_w2[0]   <= i_job.mag2;
            r_r1[0]   <= '0;
            r_r2[0]   <= '0;
            r_bus[0]  <= i_job.bus;
            r_dsec[0] <= i_job.sector;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int J = QW - 1 - i;
        logic [16:0]   t1, t2;
        logic          ge1, ge2;
        logic [QW-1:0] w1, w2;

        always_comb begin
            t1  = {r_r1[i], r_w1[i][J]};
            t2  = {r_r2[i], r_w2[i][J]};
            ge1 = (t1 >= {1'b0, r_bus[i]});
            ge2 = (t2 >= {1'b0, r_bus[i]});
            w1    = r_w1[i];
            w2    = r_w2[i];
            w1[J] = ge1;
            w2[J] = ge2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[i+1] <= 1'b0;
            end else if (adv) begin
                r_dv[i+1] <= r_dv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_w1[i+1]   <= w1;
                r_w2[i+1]   <= w2;
                r_r1[i+1]   <= ge1 ? 16'(t1 - {1'b0, r_bus[i]}) : t1[15:0];
                r_r2[i+1]   <= ge2 ? 16'(t2 - {1'b0, r_bus[i]}) : t2[15:0];
                r_bus[i+1]  <= r_bus[i];
                r_dsec[i+1] <= r_dsec[i];
            end
        end
    end

    // scaling divider: quotient fits 16 bits since each time <= sum
    logic          r_sv  [17];
    logic [RW-1:0] r_m1  [17];
    logic [RW-1:0] r_m2  [17];
    logic [15:0]   r_q1  [17];
    logic [15:0]   r_q2  [17];
    logic [SW-1:0] r_s   [17];
    logic          r_sc  [17];
    logic [2:0]    r_ssec[17];

    logic [SW-1:0] sum;
    logic          over;
    assign sum  = SW'(r_w1[QW]) + SW'(r_w2[QW]);
    assign over = (sum > SW'(i_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (adv) begin
            r_sv[0] <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1[0]   <= over ? RW'(i_limit * r_w1[QW]) : '0;
            r_m2[0]   <= over ? RW'(i_limit * r_w2[QW]) : '0;
            r_q1[0]   <= over ? 16'd0 : r_w1[QW][15:0];
            r_q2[0]   <= over ? 16'd0 : r_w2[QW][15:0];
            r_s[0]    <= sum;
            r_sc[0]   <= over;
            r_ssec[0] <= r_dsec[QW];
        end
    end

    for (genvar k = 0; k < 16; k++) begin : g_scl
        localparam int B = 15 - k;
        logic [DW-1:0] d;
        logic          ge1, ge2;
        logic [15:0]   q1, q2;

        always_comb begin
            d   = DW'(r_s[k]) << B;
            ge1 = r_sc[k] && ({1'b0, r_m1[k]} >= d);
            ge2 = r_sc[k] && ({1'b0, r_m2[k]} >= d);
            q1    = r_q1[k];
            q2    = r_q2[k];
            q1[B] = q1[B] | ge1;
            q2[B] = q2[B] | ge2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (adv) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_m1[k+1]   <= ge1 ? r_m1[k] - d[RW-1:0] : r_m1[k];
                r_m2[k+1]   <= ge2 ? r_m2[k] - d[RW-1:0] : r_m2[k];
                r_q1[k+1]   <= q1;
                r_q2[k+1]   <= q2;
                r_s[k+1]    <= r_s[k];
                r_sc[k+1]   <= r_sc[k];
                r_ssec[k+1] <= r_ssec[k];
            end
        end
    end

    // seven-segment compare values
    logic [16:0] tsum, tb_w, tc_w;
    logic [15:0] ta, tb, tc;
    t_out_item   res;

    always_comb begin
        tsum = {1'b0, r_q1[16]} + {1'b0, r_q2[16]};
        ta   = (tsum > {1'b0, i_period}) ? 16'd0 : 16'((17'(i_period) - tsum) >> 2);
        tb_w = {1'b0, ta} + 17'(r_q1[16] >> 1);
        tb   = tb_w[16] ? 16'hFFFF : tb_w[15:0];
        tc_w = {1'b0, tb} + 17'(r_q2[16] >> 1);
        tc   = tc_w[16] ? 16'hFFFF : tc_w[15:0];

        res.sector_code  = r_ssec[16];
        res.times_scaled = r_sc[16];
        case (r_ssec[16])
            SEC_N1:  begin res.duty_a = tb; res.duty_b = ta; res.duty_c = tc; end
            SEC_N5:  begin res.duty_a = tc; res.duty_b = ta; res.duty_c = tb; end
            SEC_N4:  begin res.duty_a = tc; res.duty_b = tb; res.duty_c = ta; end
            SEC_N6:  begin res.duty_a = tb; res.duty_b = tc; res.duty_c = ta; end
            SEC_N2:  begin res.duty_a = ta; res.duty_b = tc; res.duty_c = tb; end
            default: begin res.duty_a = ta; res.duty_b = tb; res.duty_c = tc; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_sv[16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

endmodule

### hdl/inverse_park_svpwm_duty_unit.sv
// ----------------------------------------------------------------------------
// inverse_park_svpwm_duty_unit
// Inverse Park transform and seven-segment SVPWM compare value generation.
// ----------------------------------------------------------------------------
// Pipeline: 6 front stages, the queue, a 34-step bus-voltage divider, a
//   16-step scaling divider with its setup stage, and the output register.
// Throughput: one beat per cycle while the queue has room and the result
//   side is ready; both sides fully pipelined.
// Reset: synchronous active low; clears pipeline valids and the queue,
//   pwm_period returns to 1000 and vector_time_limit to 950.
module inverse_park_svpwm_duty_unit import ipsv_pkg::*; #(
    parameter int FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipsv_in_if.sink     i_in,
    ipsv_out_if.source  o_out,
    ipsv_cfg_if.sink    i_cfg
);

    logic [15:0] r_period, r_limit;
    logic        push, pop, qvalid, room;
    t_job        push_job, pop_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd1000;
            r_limit  <= 16'd950;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_PERIOD: r_period <= i_cfg.data.wdata;
                CFG_LIMIT:  r_limit  <= i_cfg.data.wdata;
                default:    ;
            endcase
        end
    end

    ipsv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_period (r_period),
        .i_room   (room),
        .i_in     (i_in),
        .o_push   (push),
        .o_job    (push_job)
    );

    ipsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_job   (pop_job),
        .o_room  (room)
    );

    ipsv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_period (r_period),
        .i_limit  (r_limit),
        .i_valid  (qvalid),
        .i_job    (pop_job),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // zero-vector sectors carry no active time
    a_zero_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.data.sector_code == 3'd0 || o_out.data.sector_code == 3'd7)
        |-> !o_out.data.times_scaled && o_out.data.duty_a == o_out.data.duty_b
            && o_out.data.duty_b == o_out.data.duty_c)
        else $error("zero sector with active vector time");

    // sector 1 puts Ta on B, Tb on A, Tc on C
    a_sector1_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.sector_code == SEC_N1
        |-> o_out.data.duty_b <= o_out.data.duty_a && o_out.data.duty_a <= o_out.data.duty_c)
        else $error("sector 1 compare values out of order");

    // no pop from an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> qvalid)
        else $error("queue popped while empty");

endmodule
